/* design/twmv_pkg.sv */
// Shared types and constants for the ternary-weight matrix-vector block.
// Item and accumulator-step structs, field widths and trit codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twmv_pkg;

  localparam int LANES   = 4;
  localparam int ACT_W   = 8;
  localparam int TRIT_W  = 2;
  localparam int LANE_W  = 3;
  localparam int SUM_W   = 25;
  localparam int IDX_W   = 12;
  localparam int ROWS_W  = 13;
  localparam int TERM_W  = ACT_W + 1;
  localparam int GRP_W   = TERM_W + 2;

  localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b00;
  localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b01;
  localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b10;
  localparam logic [TRIT_W-1:0] TRIT_IDLE = 2'b11;

  localparam logic [LANE_W-1:0] LANES_FULL = 3'd4;

  typedef struct packed {
    logic [LANES*TRIT_W-1:0]    weight_byte;
    logic [LANES-1:0][ACT_W-1:0] act;
    logic [LANE_W-1:0]          lanes_valid;
    logic                       last_in_row;
  } item_t;

  typedef struct packed {
    logic                    take;
    logic                    last;
    logic signed [GRP_W-1:0] group;
  } acc_step_t;

endpackage

`default_nettype wire

/* design/ternary_weight_matvec.sv */
// Top level: input word register, ternary group sum, row accumulator.
// Path: a row's closing word goes through the input register, then the result register, to out_tvalid.
// Throughput: one word per cycle unless a row-closing word waits, set by the combinational sum-and-saturate path.
// Backpressure: a row-closing word waits in the input register while a result is unread.
// Reset (rst_n low, synchronous): accumulator and row index to 0, row_count to 1.
// Depends on twmv_pkg, twmv_lane_sum, twmv_accum.
`timescale 1ns / 1ps
`default_nettype none

module ternary_weight_matvec
  import twmv_pkg::*;
#(
  parameter int MAX_COLS = 65536,
  parameter int MAX_ROWS = 4096
) (
  input  wire               clk,
  input  wire               rst_n,
  // configuration: row_count
  input  wire               cfg_wr_en,
  input  wire  [ROWS_W-1:0] cfg_wr_data,
  // input words
  input  wire               in_tvalid,
  output logic              in_tready,
  // [7:0] weight_byte, [15:8] act_0, [23:16] act_1, [31:24] act_2,
  // [39:32] act_3, [42:40] lanes_valid, [47:43] zero
  input  wire  [47:0]       in_tdata,
  input  wire               in_tlast,    // last_in_row
  // result words
  output logic              out_tvalid,
  input  wire               out_tready,
  // [24:0] row_sum, [36:25] row_index, [39:37] zero
  output logic [39:0]       out_tdata,
  output logic              out_tlast    // last_row
);

  logic [ROWS_W-1:0] row_count_r;
  item_t             item_r;
  logic              item_vld_r;
  logic              advance;
  logic              out_valid;
  logic signed [GRP_W-1:0]  group;
  logic signed [SUM_W-1:0]  row_sum;
  logic [IDX_W-1:0]         row_index;
  logic                     last_row;
  acc_step_t                step;

  // Row count register: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWS_W'(1);
    end else if (cfg_wr_en) begin
      row_count_r <= cfg_wr_data;
    end
  end

  // Advance the held word unless it closes a row and the result slot is still full.
  assign advance   = item_vld_r && (!item_r.last_in_row || !out_valid || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  // Hold the payload; it needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.weight_byte <= in_tdata[7:0];
      item_r.act[0]      <= in_tdata[15:8];
      item_r.act[1]      <= in_tdata[23:16];
      item_r.act[2]      <= in_tdata[31:24];
      item_r.act[3]      <= in_tdata[39:32];
      item_r.lanes_valid <= in_tdata[42:40];
      item_r.last_in_row <= in_tlast;
    end
  end

  twmv_lane_sum u_lane_sum (
    .item  (item_r),
    .group (group)
  );

  assign step.take  = advance;
  assign step.last  = item_r.last_in_row;
  assign step.group = group;

  twmv_accum #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .row_count (row_count_r),
    .out_ready (out_tready),
    .out_valid (out_valid),
    .row_sum   (row_sum),
    .row_index (row_index),
    .last_row  (last_row)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {3'b000, row_index, row_sum};
  assign out_tlast  = last_row;

endmodule

`default_nettype wire

/* design/twmv_lane_sum.sv */
// Four-lane ternary group sum of one registered item.
// Depends on twmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twmv_lane_sum
  import twmv_pkg::*;
(
  input  item_t                   item,
  output logic signed [GRP_W-1:0] group
);

  logic [LANE_W-1:0]        lanes_eff;
  logic signed [TERM_W-1:0] term [LANES];
  logic signed [GRP_W-1:0]  acc;

  assign lanes_eff = (item.lanes_valid > LANES_FULL) ? LANES_FULL : item.lanes_valid;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      term[i] = '0;
      if (LANE_W'(i) < lanes_eff) begin
        unique case (item.weight_byte[TRIT_W*i +: TRIT_W])
          TRIT_POS:  term[i] = TERM_W'($signed(item.act[i]));
          TRIT_NEG:  term[i] = -TERM_W'($signed(item.act[i]));
          TRIT_ZERO: term[i] = '0;
          TRIT_IDLE: term[i] = '0;
          default:   term[i] = '0;
        endcase
      end
    end
  end

  // Independent lane terms, one adder tree.
  always_comb begin
    acc = '0;
    for (int i = 0; i < LANES; i++) begin
      acc = acc + GRP_W'(term[i]);
    end
  end

  assign group = acc;

endmodule

`default_nettype wire

/* design/twmv_accum.sv */
// Saturating row accumulator, row counter and result register.
// Depends on twmv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twmv_accum
  import twmv_pkg::*;
#(
  parameter int MAX_COLS = 65536,
  parameter int MAX_ROWS = 4096
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  acc_step_t                step,
  input  wire [ROWS_W-1:0]         row_count,
  input  wire                      out_ready,
  output logic                     out_valid,
  output logic signed [SUM_W-1:0]  row_sum,
  output logic [IDX_W-1:0]         row_index,
  output logic                     last_row
);

  localparam logic signed [SUM_W:0] SUM_BOUND = (SUM_W + 1)'(MAX_COLS * 128);
  localparam logic [ROWS_W-1:0]     ROWS_MAX  = ROWS_W'(MAX_ROWS);

  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] sum_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    lrow_r;

  logic signed [SUM_W:0]   acc_ext;
  logic signed [SUM_W-1:0] acc_sat;
  logic [ROWS_W-1:0]       rows_eff;
  logic                    final_row;

  assign acc_ext = (SUM_W + 1)'(acc_r) + (SUM_W + 1)'(step.group);

  always_comb begin
    priority if (acc_ext > SUM_BOUND) begin
      acc_sat = SUM_W'(SUM_BOUND);
    end else if (acc_ext < -SUM_BOUND) begin
      acc_sat = SUM_W'(-SUM_BOUND);
    end else begin
      acc_sat = SUM_W'(acc_ext);
    end
  end

  always_comb begin
    priority if (row_count == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (row_count > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = row_count;
    end
  end

  assign final_row = {1'b0, cnt_r} >= (rows_eff - ROWS_W'(1));

  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (step.take) begin
      if (step.last) begin
        acc_nxt       = '0;
        cnt_nxt       = final_row ? '0 : cnt_r + IDX_W'(1);
        out_valid_nxt = 1'b1;
      end else begin
        acc_nxt = acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload: load on a row's closing word.
  always_ff @(posedge clk) begin
    if (step.take && step.last) begin
      sum_r  <= acc_sat;
      idx_r  <= cnt_r;
      lrow_r <= final_row;
    end
  end

  assign out_valid = out_valid_r;
  assign row_sum   = sum_r;
  assign row_index = idx_r;
  assign last_row  = lrow_r;

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.take && step.last |=> acc_r == '0)
    else $error("accumulator not cleared after row close");

  a_close_shows: assert property (@(posedge clk) disable iff (!rst_n)
    step.take && step.last |=> out_valid_r)
    else $error("row close did not raise result valid");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    step.take && step.last |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step.take && step.last && final_row |=> cnt_r == '0)
    else $error("row counter failed to wrap");

endmodule

`default_nettype wire

/* bench/ternary_weight_matvec_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for ternary_weight_matvec: streams packed trit/activation words,
// folds each accepted word into a local row-sum model and checks every result word.
// Depends on twmv_pkg and the ternary_weight_matvec RTL.

module ternary_weight_matvec_tb;
  import twmv_pkg::*;

  localparam int     MAX_COLS      = 65536;
  localparam int     MAX_ROWS      = 4096;
  localparam longint SUM_BOUND     = longint'(MAX_COLS) * 128;
  // Input register plus the accumulator stage; a word that closes no row can
  // still be in flight when the last result arrives.
  localparam int     SETTLE_CYCLES = 4;
  localparam int     LONG_WORDS    = 200;  // non-closing words per long extreme-magnitude row

  typedef struct {
    logic signed [SUM_W-1:0] row_sum;
    logic [IDX_W-1:0]        row_index;
    logic                    last_row;
  } row_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [ROWS_W-1:0] cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;    // weight_byte, act_0..act_3, lanes_valid, pad
  logic              in_tlast;    // last_in_row
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [39:0]       out_tdata;   // row_sum, row_index, pad
  logic              out_tlast;   // last_row

  // Row-sum model state, mirrors the block after reset
  logic [ROWS_W-1:0] rows_per_pass;
  longint            row_acc;
  logic [IDX_W-1:0]  row_ctr;
  row_result_t       pending_rows[$];

  int words_sent;
  int rows_checked;
  int mismatches;
  int burst_left;

  ternary_weight_matvec #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print the first few mismatches, count all of them
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Fold one accepted word into the row accumulator; queue the row result
  // when the word closes its row.
  function automatic void fold_word(input item_t w);
    longint      grp;
    int          lanes;
    int          rows;
    row_result_t r;
    grp = 0;
    // lane counts above four count as four, zero counts nothing
    lanes = (w.lanes_valid > LANES) ? LANES : int'(w.lanes_valid);
    for (int i = 0; i < lanes; i++) begin
      case (w.weight_byte[TRIT_W*i +: TRIT_W])
        TRIT_POS: grp += longint'($signed(w.act[i]));
        TRIT_NEG: grp -= longint'($signed(w.act[i]));
        default:  ;
      endcase
    end
    // clamp after every word; a clamped sum keeps accumulating from the bound
    row_acc += grp;
    if (row_acc > SUM_BOUND) row_acc = SUM_BOUND;
    if (row_acc < -SUM_BOUND) row_acc = -SUM_BOUND;
    words_sent++;
    if (!w.last_in_row) return;
    // a row count of zero acts as one, anything above MAX_ROWS as MAX_ROWS
    if (rows_per_pass == 0) rows = 1;
    else if (rows_per_pass > MAX_ROWS) rows = MAX_ROWS;
    else rows = int'(rows_per_pass);
    r.row_sum   = row_acc[SUM_W-1:0];
    r.row_index = row_ctr;
    // an index at or past the end (row count lowered mid-pass) closes the pass
    r.last_row  = (int'(row_ctr) >= rows - 1);
    pending_rows.push_back(r);
    row_acc = 0;
    row_ctr = r.last_row ? '0 : row_ctr + 1'b1;
  endfunction

  function automatic item_t make_word(input logic [LANE_W-1:0] lanes, input logic last);
    item_t w;
    w.weight_byte = 8'($urandom);
    for (int i = 0; i < LANES; i++) w.act[i] = ACT_W'($urandom);
    w.lanes_valid = lanes;
    w.last_in_row = last;
    return w;
  endfunction

  function automatic item_t uniform_word(input logic [7:0] wb, input logic [7:0] act,
                                         input logic [LANE_W-1:0] lanes, input logic last);
    item_t w;
    w.weight_byte = wb;
    for (int i = 0; i < LANES; i++) w.act[i] = act;
    w.lanes_valid = lanes;
    w.last_in_row = last;
    return w;
  endfunction

  // Drive one word at the falling edge and hold it until the block takes it.
  // The sender runs in bursts; between bursts drop valid for a random gap.
  task automatic send_word(input item_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 48'({$urandom, $urandom});
        in_tlast  <= 1'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 400)
                                                : $urandom_range(1, 16);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, w.lanes_valid, w.act[3], w.act[2], w.act[1], w.act[0],
                  w.weight_byte};
    in_tlast  <= w.last_in_row;
    do @(posedge clk); while (!in_tready);
    fold_word(w);
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
  endtask

  // Write row_count only once the block has gone quiet
  task automatic write_row_count(input logic [ROWS_W-1:0] value);
    hold_input();
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= ROWS_W'($urandom);
    rows_per_pass = value;
  endtask

  task automatic send_random_row();
    int               len;
    int               pick;
    logic [LANE_W-1:0] lanes;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      lanes = LANES_FULL;
      // short final group
      if (k == len - 1 && $urandom_range(0, 2) == 0) lanes = LANE_W'($urandom_range(1, 3));
      // odd lane counts: zero, or five to seven
      if ($urandom_range(0, 15) == 0) begin
        pick  = $urandom_range(4, 7);
        lanes = (pick == 4) ? '0 : LANE_W'(pick);
      end
      send_word(make_word(lanes, k == len - 1));
    end
  endtask

  // Row count still at its reset value of one: every row is index 0 and last.
  // Hit both activation extremes with every trit code and every lane count.
  task automatic test_default_pass();
    send_word(uniform_word(8'hAA, 8'h80, LANES_FULL, 1'b1));
    send_word(uniform_word(8'h55, 8'h80, LANES_FULL, 1'b1));
    send_word(uniform_word(8'h55, 8'h7F, LANES_FULL, 1'b1));
    send_word(uniform_word(8'hAA, 8'h7F, LANES_FULL, 1'b1));
    send_word(uniform_word(8'hFF, 8'h80, LANES_FULL, 1'b1));
    send_word(uniform_word(8'h00, 8'h7F, LANES_FULL, 1'b1));
    send_word(uniform_word(8'h1B, 8'h80, LANES_FULL, 1'b1));
    send_word(uniform_word(8'hE4, 8'h7F, LANES_FULL, 1'b1));
    for (int l = 0; l < 8; l++) send_word(uniform_word(8'h55, 8'h7F, LANE_W'(l), 1'b1));
    // one multi-word row ending in a short group
    for (int k = 0; k < 3; k++) send_word(make_word(LANES_FULL, 1'b0));
    send_word(make_word(3'd3, 1'b1));
  endtask

  // Register extremes: 4096, 0, 1 and 8191 (acts as 4096)
  task automatic test_row_count_extremes();
    write_row_count(ROWS_W'(MAX_ROWS));
    repeat (3) send_word(make_word(LANES_FULL, 1'b1));
    write_row_count(0);
    repeat (2) send_word(make_word(LANES_FULL, 1'b1));
    write_row_count(1);
    repeat (2) send_word(make_word(LANES_FULL, 1'b1));
    write_row_count('1);
    repeat (3) send_word(make_word(LANES_FULL, 1'b1));
  endtask

  // Lower the row count below the current index mid-pass
  task automatic test_row_count_lowered();
    write_row_count(200);
    repeat (10) begin
      send_word(make_word(LANES_FULL, 1'b0));
      send_word(make_word(LANES_FULL, 1'b1));
    end
    write_row_count(4);
    repeat (5) send_random_row();
    write_row_count(7);
    repeat (3) send_random_row();
    write_row_count(2);
    repeat (3) send_random_row();
  endtask

  // Long rows of extreme-magnitude words: wide sums of either sign
  task automatic test_long_rows();
    write_row_count(3);
    repeat (LONG_WORDS) send_word(uniform_word(8'hAA, 8'h80, LANES_FULL, 1'b0));
    send_word(uniform_word(8'hAA, 8'h80, LANES_FULL, 1'b1));
    repeat (LONG_WORDS) send_word(uniform_word(8'h55, 8'h80, LANES_FULL, 1'b0));
    send_word(uniform_word(8'h55, 8'h7F, LANES_FULL, 1'b1));
  endtask

  // Phases of random rows, each under a fresh row count
  task automatic test_random_rows(input int target);
    int first;
    first = words_sent;
    while (words_sent - first < target) begin
      case ($urandom_range(0, 5))
        0:       write_row_count(1);
        1:       write_row_count(ROWS_W'($urandom_range(2, 4)));
        2:       write_row_count(ROWS_W'($urandom_range(5, 40)));
        3:       write_row_count(ROWS_W'($urandom_range(41, MAX_ROWS)));
        4:       write_row_count(0);
        default: write_row_count(ROWS_W'($urandom_range(MAX_ROWS + 1, 8191)));
      endcase
      repeat ($urandom_range(10, 40)) send_random_row();
    end
  endtask

  // Result stalls: change the out_tready pattern after each random span
  initial begin : result_stall
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 256);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= (k % 5 == 0);
        endcase
      end
    end
  end

  // Compare each result word with the oldest queued row result
  always @(posedge clk) begin : row_check
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("result word with no row pending: sum %0d index %0d",
                                  $signed(out_tdata[SUM_W-1:0]),
                                  out_tdata[SUM_W+IDX_W-1:SUM_W]));
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (out_tdata[SUM_W-1:0] !== want.row_sum)
          report_mismatch($sformatf("row_sum %0d, want %0d",
                                    $signed(out_tdata[SUM_W-1:0]), want.row_sum));
        if (out_tdata[SUM_W+IDX_W-1:SUM_W] !== want.row_index)
          report_mismatch($sformatf("row_index %0d, want %0d",
                                    out_tdata[SUM_W+IDX_W-1:SUM_W], want.row_index));
        if (out_tlast !== want.last_row)
          report_mismatch($sformatf("last_row %b, want %b at index %0d",
                                    out_tlast, want.last_row, want.row_index));
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d row results outstanding", pending_rows.size());
    $display("** ternary_weight_matvec: FAILED **");
    $finish;
  end

  initial begin : run
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    rows_per_pass = 1;
    row_acc       = 0;
    row_ctr       = '0;
    words_sent    = 0;
    rows_checked  = 0;
    mismatches    = 0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_pass();
    test_row_count_extremes();
    test_row_count_lowered();
    test_long_rows();
    test_random_rows(1000);

    // drain: wait out every pending row, then let the block settle
    hold_input();
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (4 * SETTLE_CYCLES) @(negedge clk);

    $display("Streamed %0d words and checked %0d row results.", words_sent, rows_checked);
    $display("Row counts 0, 1, 4096 and up, mid-pass reductions, long extreme rows, lanes 0-7.");
    if (mismatches == 0) begin
      $display("** ternary_weight_matvec: PASSED **");
    end else begin
      $display("** ternary_weight_matvec: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/twmv_pkg.sv
design/twmv_lane_sum.sv
design/twmv_accum.sv
design/ternary_weight_matvec.sv
bench/ternary_weight_matvec_tb.sv
